@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, muted while reset is asserted.
`define ASSERT_NEXT(label, clk, ante, cons, rstn) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ sv/lca_pkg.sv @@
`timescale 1ns / 1ps

package lca_pkg;

    // Node ids are 10 bits wide and every id names a table entry.
    localparam int ID_W       = 10;
    localparam int NODE_COUNT = 1 << ID_W;
    localparam int DEPTH_W    = $clog2(NODE_COUNT + 1);

    // Stream widths: node_a and node_b in s_tdata, ancestor in m_tdata.
    localparam int S_TDATA_W = ((2 * ID_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;

    // Item kinds carried on s_tuser.
    typedef enum logic [S_TUSER_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // One entry of the parent table.
    typedef struct packed {
        logic            has_parent;
        logic [ID_W-1:0] link;
    } link_word_t;

    // Write port of the parent table.
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
        link_word_t      data;
    } ram_wr_t;

    // Micro-PC and step addresses of the control program.
    typedef logic [3:0] upc_t;
    localparam upc_t S_IDLE  = 4'd0;
    localparam upc_t S_CLEAR = 4'd1;
    localparam upc_t S_EDGE  = 4'd2;
    localparam upc_t S_START = 4'd3;
    localparam upc_t S_DEPTH = 4'd4;
    localparam upc_t S_CHECK = 4'd5;
    localparam upc_t S_LIFT  = 4'd6;
    localparam upc_t S_MEET  = 4'd7;
    localparam upc_t S_EMIT  = 4'd8;

    // Control word fields.
    typedef enum logic [1:0] {
        MW_NONE  = 2'd0,
        MW_CLEAR = 2'd1,
        MW_EDGE  = 2'd2
    } mem_op_t;

    typedef enum logic [2:0] {
        LN_HOLD   = 3'd0,
        LN_START  = 3'd1,
        LN_RELOAD = 3'd2,
        LN_DEPTH  = 3'd3,
        LN_LIFT   = 3'd4,
        LN_MEET   = 3'd5
    } lane_op_t;

    typedef enum logic [1:0] {
        FD_HOLD  = 2'd0,
        FD_CLEAR = 2'd1,
        FD_MATCH = 2'd2
    } found_op_t;

    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_DISPATCH  = 3'd1,
        C_CLR_LAST  = 3'd2,
        C_ADVANCE   = 3'd3,
        C_ROOTS_OK  = 3'd4,
        C_DEPTH_NE  = 3'd5,
        C_MEET_MORE = 3'd6,
        C_OUT_FREE  = 3'd7
    } cond_t;

    typedef struct packed {
        logic      ready;
        mem_op_t   mem_op;
        lane_op_t  lane_op;
        found_op_t found_op;
        logic      emit;
        cond_t     cond;
        upc_t      tgt_true;
        upc_t      tgt_false;
    } ctrl_t;

    // Datapath flags that the jump conditions test.
    typedef struct packed {
        logic clr_last;
        logic advance;
        logic roots_ok;
        logic depth_ne;
        logic meet_more;
    } dp_stat_t;

endpackage

@@ sv/lca_link_ram.sv @@
`timescale 1ns / 1ps

module lca_link_ram (
    input  logic                      aclk,
    input  lca_pkg::ram_wr_t          wr,
    input  logic [lca_pkg::ID_W-1:0]  rd_addr_a,
    input  logic [lca_pkg::ID_W-1:0]  rd_addr_b,
    output lca_pkg::link_word_t       rd_data_a,
    output lca_pkg::link_word_t       rd_data_b
);
    import lca_pkg::*;

    link_word_t mem [NODE_COUNT];

    // One write port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Two registered read ports, one for each walk.
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ sv/lca_sequencer.sv @@
`timescale 1ns / 1ps

module lca_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  lca_pkg::op_t      op,
    input  logic              out_free,
    input  lca_pkg::dp_stat_t stat,
    output lca_pkg::ctrl_t    ctrl
);
    import lca_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic take;
    upc_t dispatch_tgt;

    // Control program, one word per step.
    function automatic ctrl_t ucode(input upc_t pc);
        ctrl_t w;
        w = '{ready: 1'b0, mem_op: MW_NONE, lane_op: LN_HOLD, found_op: FD_HOLD,
               emit: 1'b0, cond: C_ALWAYS, tgt_true: S_IDLE, tgt_false: S_IDLE};
        case (pc)
            S_IDLE: begin
                w.ready     = 1'b1;
                w.cond      = C_DISPATCH;
            end
            S_CLEAR: begin
                w.mem_op    = MW_CLEAR;
                w.cond      = C_CLR_LAST;
                w.tgt_false = S_CLEAR;
            end
            S_EDGE: begin
                w.mem_op    = MW_EDGE;
            end
            S_START: begin
                w.lane_op   = LN_START;
                w.found_op  = FD_CLEAR;
                w.tgt_true  = S_DEPTH;
            end
            S_DEPTH: begin
                w.lane_op   = LN_DEPTH;
                w.cond      = C_ADVANCE;
                w.tgt_true  = S_DEPTH;
                w.tgt_false = S_CHECK;
            end
            S_CHECK: begin
                w.lane_op   = LN_RELOAD;
                w.cond      = C_ROOTS_OK;
                w.tgt_true  = S_LIFT;
                w.tgt_false = S_EMIT;
            end
            S_LIFT: begin
                w.lane_op   = LN_LIFT;
                w.cond      = C_DEPTH_NE;
                w.tgt_true  = S_LIFT;
                w.tgt_false = S_MEET;
            end
            S_MEET: begin
                w.lane_op   = LN_MEET;
                w.found_op  = FD_MATCH;
                w.cond      = C_MEET_MORE;
                w.tgt_true  = S_MEET;
                w.tgt_false = S_EMIT;
            end
            S_EMIT: begin
                w.emit      = 1'b1;
                w.cond      = C_OUT_FREE;
                w.tgt_false = S_EMIT;
            end
            default: begin
                w.cond      = C_ALWAYS;
            end
        endcase
        return w;
    endfunction

    assign ctrl = ucode(upc_reg);

    // Entry step for each item kind.
    always_comb begin
        case (op)
            OP_CLEAR: dispatch_tgt = S_CLEAR;
            OP_EDGE:  dispatch_tgt = S_EDGE;
            OP_QUERY: dispatch_tgt = S_START;
            default:  dispatch_tgt = S_IDLE;
        endcase
    end

    // Jump condition select.
    always_comb begin
        case (ctrl.cond)
            C_ALWAYS:    take = 1'b1;
            C_DISPATCH:  take = accept;
            C_CLR_LAST:  take = stat.clr_last;
            C_ADVANCE:   take = stat.advance;
            C_ROOTS_OK:  take = stat.roots_ok;
            C_DEPTH_NE:  take = stat.depth_ne;
            C_MEET_MORE: take = stat.meet_more;
            C_OUT_FREE:  take = out_free;
            default:     take = 1'b1;
        endcase
    end

    // Next step: the dispatch table on a transfer, otherwise one of the two targets.
    always_comb begin
        if (ctrl.cond == C_DISPATCH) begin
            upc_next = take ? dispatch_tgt : ctrl.tgt_false;
        end else begin
            upc_next = take ? ctrl.tgt_true : ctrl.tgt_false;
        end
    end

    // Reset starts the clearing pass over the parent table.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= S_CLEAR;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ sv/lca_datapath.sv @@
`timescale 1ns / 1ps

module lca_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lca_pkg::ctrl_t            ctrl,
    input  logic [lca_pkg::ID_W-1:0]  node_a,
    input  logic [lca_pkg::ID_W-1:0]  node_b,
    input  lca_pkg::link_word_t       q_a,
    input  lca_pkg::link_word_t       q_b,
    output logic [lca_pkg::ID_W-1:0]  rd_addr_a,
    output logic [lca_pkg::ID_W-1:0]  rd_addr_b,
    output lca_pkg::ram_wr_t          wr,
    output lca_pkg::dp_stat_t         stat,
    output logic                      found,
    output logic [lca_pkg::ID_W-1:0]  ancestor
);
    import lca_pkg::*;

    logic [ID_W-1:0]    ptr_a_reg, ptr_a_next;
    logic [ID_W-1:0]    ptr_b_reg, ptr_b_next;
    logic [DEPTH_W-1:0] dep_a_reg, dep_a_next;
    logic [DEPTH_W-1:0] dep_b_reg, dep_b_next;
    logic [ID_W-1:0]    clr_idx_reg, clr_idx_next;
    logic               found_reg, found_next;
    logic               walk_a, walk_b;
    logic               clr_last;

    // A walk may take one more step while a parent exists and the step cap is not hit.
    assign walk_a   = q_a.has_parent && (dep_a_reg != DEPTH_W'(NODE_COUNT));
    assign walk_b   = q_b.has_parent && (dep_b_reg != DEPTH_W'(NODE_COUNT));
    assign clr_last = (clr_idx_reg == ID_W'(NODE_COUNT - 1));

    assign stat.clr_last  = clr_last;
    assign stat.advance   = walk_a || walk_b;
    assign stat.roots_ok  = !q_a.has_parent && !q_b.has_parent;
    assign stat.depth_ne  = (dep_a_reg != dep_b_reg);
    assign stat.meet_more = (ptr_a_reg != ptr_b_reg) && q_a.has_parent && q_b.has_parent;

    // Cursor and depth updates for the two walks.
    always_comb begin
        ptr_a_next = ptr_a_reg;
        ptr_b_next = ptr_b_reg;
        dep_a_next = dep_a_reg;
        dep_b_next = dep_b_reg;
        case (ctrl.lane_op)
            LN_HOLD: begin
            end
            LN_START: begin
                ptr_a_next = node_a;
                ptr_b_next = node_b;
                dep_a_next = '0;
                dep_b_next = '0;
            end
            LN_RELOAD: begin
                ptr_a_next = node_a;
                ptr_b_next = node_b;
            end
            LN_DEPTH: begin
                if (walk_a) begin
                    ptr_a_next = q_a.link;
                    dep_a_next = dep_a_reg + DEPTH_W'(1);
                end
                if (walk_b) begin
                    ptr_b_next = q_b.link;
                    dep_b_next = dep_b_reg + DEPTH_W'(1);
                end
            end
            LN_LIFT: begin
                if (dep_a_reg > dep_b_reg) begin
                    ptr_a_next = q_a.link;
                    dep_a_next = dep_a_reg - DEPTH_W'(1);
                end
                if (dep_b_reg > dep_a_reg) begin
                    ptr_b_next = q_b.link;
                    dep_b_next = dep_b_reg - DEPTH_W'(1);
                end
            end
            LN_MEET: begin
                if (stat.meet_more) begin
                    ptr_a_next = q_a.link;
                    ptr_b_next = q_b.link;
                end
            end
            default: begin
            end
        endcase
    end

    // The table is always read at the next cursor, so its output matches the cursor.
    assign rd_addr_a = ptr_a_next;
    assign rd_addr_b = ptr_b_next;

    // Table writes: the clearing sweep or one edge.
    always_comb begin
        wr           = '{en: 1'b0, addr: clr_idx_reg, data: '0};
        clr_idx_next = clr_idx_reg;
        case (ctrl.mem_op)
            MW_NONE: begin
            end
            MW_CLEAR: begin
                wr.en        = 1'b1;
                clr_idx_next = clr_last ? '0 : clr_idx_reg + ID_W'(1);
            end
            MW_EDGE: begin
                wr.en              = 1'b1;
                wr.addr            = node_b;
                wr.data.has_parent = 1'b1;
                wr.data.link       = node_a;
            end
            default: begin
            end
        endcase
    end

    // Match flag of the query in progress.
    always_comb begin
        case (ctrl.found_op)
            FD_HOLD:  found_next = found_reg;
            FD_CLEAR: found_next = 1'b0;
            FD_MATCH: found_next = (ptr_a_reg == ptr_b_reg);
            default:  found_next = found_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else begin
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_a_reg <= ptr_a_next;
        ptr_b_reg <= ptr_b_next;
        dep_a_reg <= dep_a_next;
        dep_b_reg <= dep_b_next;
        found_reg <= found_next;
    end

    assign found    = found_reg;
    assign ancestor = found_reg ? ptr_a_reg : '0;

endmodule

@@ sv/lowest_common_ancestor_engine.sv @@
`timescale 1ns / 1ps

// Lowest common ancestor engine: keeps a forest of up to 1024 nodes as a parent
// table and answers common ancestor queries. An input transfer carries its kind
// on s_tuser (clear, edge, query) and two node ids on s_tdata; a later edge for
// the same child replaces its parent. Only a query returns a result transfer:
// m_tuser says whether an ancestor was found and m_tdata carries its id, zero
// if not. After reset, and after each clear transfer, the block sweeps all
// NODE_COUNT (1024) table entries and takes no input meanwhile. A query walks
// both nodes to their roots, lifts the deeper one, then steps both up until
// they meet; the parent table serves one link per walk per cycle. A result
// waits in the output register while the next transfer is taken.
module lowest_common_ancestor_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lca_pkg::S_TDATA_W-1:0]   s_tdata,   // node_a, node_b, zero pad
    input  logic [lca_pkg::S_TUSER_W-1:0]   s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lca_pkg::M_TDATA_W-1:0]   m_tdata,   // ancestor, zero pad
    output logic [0:0]                      m_tuser    // found
);
    import lca_pkg::*;

    ctrl_t      ctrl;
    dp_stat_t   stat;
    ram_wr_t    wr;
    link_word_t q_a, q_b;
    logic [ID_W-1:0] rd_addr_a, rd_addr_b;
    logic [ID_W-1:0] node_a_reg, node_b_reg;
    logic            accept;
    logic            out_free;
    logic            found;
    logic [ID_W-1:0] ancestor;
    logic            m_tvalid_reg;
    logic            m_found_reg;
    logic [ID_W-1:0] m_anc_reg;

    assign s_tready = ctrl.ready;
    assign accept   = s_tvalid && ctrl.ready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Node ids of the accepted transfer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            node_a_reg <= s_tdata[ID_W-1:0];
            node_b_reg <= s_tdata[2*ID_W-1:ID_W];
        end
    end

    lca_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .op       (op_t'(s_tuser)),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    lca_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .node_a    (node_a_reg),
        .node_b    (node_b_reg),
        .q_a       (q_a),
        .q_b       (q_b),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr        (wr),
        .stat      (stat),
        .found     (found),
        .ancestor  (ancestor)
    );

    lca_link_ram u_ram (
        .aclk      (aclk),
        .wr        (wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (q_a),
        .rd_data_b (q_b)
    );

    // Output register; a result is loaded when the register is empty or draining.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit && out_free) begin
            m_found_reg <= found;
            m_anc_reg   <= ancestor;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W){1'b0}}, m_anc_reg};

endmodule

@@ sv/lca_checker.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lca_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lca_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [lca_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lca_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [0:0]                      m_tuser
);
    import lca_pkg::*;

    logic work_item;

    // Clear, edge and query transfers all start work that holds off the next one.
    assign work_item = s_tvalid && s_tready &&
                       (s_tuser == OP_CLEAR || s_tuser == OP_EDGE || s_tuser == OP_QUERY);

    // Reset starts the clearing pass, so no transfer is taken right after it.
    `ASSERT_NEXT_ALWAYS(a_reset_busy, aclk, !aresetn, !s_tready)

    // A transfer of a known kind keeps the input closed in the next cycle.
    `ASSERT_NEXT(a_item_busy, aclk, work_item, !s_tready, aresetn)

    // A not-found result carries a zero ancestor.
    `ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0)

    // A stalled result holds still.
    `ASSERT_NEXT(a_out_hold, aclk, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata) && $stable(m_tuser), aresetn)

endmodule

bind lowest_common_ancestor_engine lca_checker u_lca_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import lca_pkg::*;

    // Unused op code; the block drops such a transfer without a result.
    localparam logic [S_TUSER_W-1:0] OP_UNUSED = 2'd3;

    // Cycles without any transfer before the run is declared hung. A clear
    // sweeps all NODE_COUNT table entries.
    localparam int QUIET_LIMIT = 20000;
    // Trailing wait after the last expected answer, covering one slow query.
    localparam int DRAIN_CYCLES = 3 * NODE_COUNT + 64;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] ancestor;
    } answer_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // node_a, node_b, zero pad
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // ancestor, zero pad
    logic [0:0]           m_tuser;         // found

    // Our own copy of the forest.
    logic [ID_W-1:0] tree_parent [NODE_COUNT];
    bit              tree_linked [NODE_COUNT];

    answer_t pending_answers[$];
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      burst_left   = 0;

    lowest_common_ancestor_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Walks parent links up from a node. Returns 1 when a root is reached
    // within NODE_COUNT steps, 0 when the walk is caught in a loop.
    function automatic bit walk_depth(input logic [ID_W-1:0] id, output int unsigned depth);
        logic [ID_W-1:0] cur;
        cur = id;
        depth = 0;
        while (tree_linked[cur] && depth < NODE_COUNT) begin
            cur = tree_parent[cur];
            depth++;
        end
        return !tree_linked[cur];
    endfunction

    // Lowest common ancestor of two nodes in the current forest.
    function automatic answer_t common_ancestor(input logic [ID_W-1:0] node_a,
                                                input logic [ID_W-1:0] node_b);
        answer_t         ans;
        int unsigned     depth_a;
        int unsigned     depth_b;
        bit              ok_a;
        bit              ok_b;
        bit              ok;
        logic [ID_W-1:0] cur_a;
        logic [ID_W-1:0] cur_b;
        ok_a = walk_depth(node_a, depth_a);
        ok_b = walk_depth(node_b, depth_b);
        ok = ok_a && ok_b;
        cur_a = node_a;
        cur_b = node_b;
        if (ok) begin
            // Lift the deeper node, then step both up until they meet.
            while (depth_a > depth_b) begin
                cur_a = tree_parent[cur_a];
                depth_a--;
            end
            while (depth_b > depth_a) begin
                cur_b = tree_parent[cur_b];
                depth_b--;
            end
            while (cur_a != cur_b) begin
                if (!tree_linked[cur_a] || !tree_linked[cur_b]) begin
                    ok = 1'b0;
                    break;
                end
                cur_a = tree_parent[cur_a];
                cur_b = tree_parent[cur_b];
            end
        end
        ans.found = ok;
        ans.ancestor = ok ? cur_a : '0;
        return ans;
    endfunction

    // Sends one item, in bursts with random gaps, and updates the forest model
    // once the transfer is accepted.
    task automatic send_item(input logic [S_TUSER_W-1:0] op,
                             input logic [ID_W-1:0] node_a,
                             input logic [ID_W-1:0] node_b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - 2 * ID_W){1'b0}}, node_b, node_a};
        do @(posedge aclk); while (s_tready !== 1'b1);
        burst_left--;
        case (op)
            OP_CLEAR: begin
                foreach (tree_linked[i]) tree_linked[i] = 1'b0;
            end
            OP_EDGE: begin
                tree_parent[node_b] = node_a;
                tree_linked[node_b] = 1'b1;
            end
            OP_QUERY: begin
                pending_answers.insert(pending_answers.size(),
                                       common_ancestor(node_a, node_b));
            end
            default: ;
        endcase
    endtask

    // Receiver stalls: long ready stretches, random stalls and mostly-stalled runs.
    always @(posedge aclk) begin : receiver_pattern
        int mode;
        int mode_left;
        if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Compare each result transfer with the oldest expected answer.
    always @(posedge aclk) begin : check_results
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result found=%0b ancestor=%0d",
                         $time, m_tuser[0], m_tdata);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (m_tuser[0] !== want.found) begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, m_tuser[0]);
                    mismatches++;
                end
                if (m_tdata !== M_TDATA_W'(want.ancestor)) begin
                    $display("%0t: ancestor mismatch, expected %0d, actual %0d",
                             $time, want.ancestor, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Small hand-built tree, node id extremes, overwrite, unused op, clear, loops.
    task automatic test_directed();
        send_item(OP_EDGE, 10'd0, 10'd1);
        send_item(OP_EDGE, 10'd0, 10'd2);
        send_item(OP_EDGE, 10'd1, 10'd3);
        send_item(OP_EDGE, 10'd1, 10'd4);
        send_item(OP_EDGE, 10'd2, 10'd1023);
        send_item(OP_QUERY, 10'd3, 10'd4);
        send_item(OP_QUERY, 10'd3, 10'd1023);
        send_item(OP_QUERY, 10'd4, 10'd4);
        send_item(OP_QUERY, 10'd1023, 10'd0);
        send_item(OP_QUERY, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd512, 10'd3);
        // A second parent for node 4 replaces the first.
        send_item(OP_EDGE, 10'd1023, 10'd4);
        send_item(OP_QUERY, 10'd3, 10'd4);
        send_item(OP_UNUSED, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd4, 10'd2);
        // After a clear every node is its own root.
        send_item(OP_CLEAR, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd3, 10'd4);
        send_item(OP_QUERY, 10'd0, 10'd0);
        // A two-node loop: walks never reach a root.
        send_item(OP_EDGE, 10'd5, 10'd6);
        send_item(OP_EDGE, 10'd6, 10'd5);
        send_item(OP_QUERY, 10'd5, 10'd6);
        send_item(OP_QUERY, 10'd5, 10'd5);
        send_item(OP_QUERY, 10'd7, 10'd6);
    endtask

    // Forests built on random ids, then queries mostly within the tree.
    task automatic test_random_forests();
        logic [ID_W-1:0] pool[$];
        logic [ID_W-1:0] qa;
        logic [ID_W-1:0] qb;
        int              size;
        for (int round = 0; round < 5; round++) begin
            pool.delete();
            // The last round builds one long chain to exercise deep walks.
            size = (round == 4) ? 24 : $urandom_range(4, 14);
            for (int k = 0; k < size; k++) begin
                pool.insert(pool.size(), ID_W'($urandom_range(0, NODE_COUNT - 1)));
            end
            send_item(OP_CLEAR, ID_W'($urandom), ID_W'($urandom));
            for (int k = 1; k < size; k++) begin
                qa = (round == 4) ? pool[k - 1] : pool[$urandom_range(0, k - 1)];
                send_item(OP_EDGE, qa, pool[k]);
            end
            repeat ($urandom_range(6, 10)) begin
                qa = pool[$urandom_range(0, size - 1)];
                qb = pool[$urandom_range(0, size - 1)];
                if ($urandom_range(0, 4) == 0) qb = ID_W'($urandom);
                send_item(OP_QUERY, qa, qb);
            end
        end
    endtask

    // Random ops, including the unused code, on ids mostly inside a narrow window
    // so that edges overlap and may close loops.
    task automatic test_random_noise();
        logic [ID_W-1:0] qa;
        logic [ID_W-1:0] qb;
        int              base;
        int              pick;
        base = $urandom_range(0, NODE_COUNT - 32);
        repeat (67) begin
            qa = ID_W'(base + $urandom_range(0, 31));
            qb = ID_W'(base + $urandom_range(0, 31));
            if ($urandom_range(0, 3) == 0) qa = ID_W'($urandom);
            if ($urandom_range(0, 3) == 0) qb = ID_W'($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_item(OP_CLEAR, qa, qb);
            end else if (pick == 1) begin
                send_item(OP_UNUSED, qa, qb);
            end else if (pick <= 10) begin
                send_item(OP_EDGE, qa, qb);
            end else begin
                send_item(OP_QUERY, qa, qb);
            end
        end
    endtask

    initial begin
        foreach (tree_linked[i]) tree_linked[i] = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_forests();
        test_random_noise();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
